// ===== rtl/core/bbs_pkg.sv =====
`timescale 1ns / 1ps
package bbs_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int POS_W        = 13;
	localparam int VAL_W        = 64;
	localparam int VLEN_W       = 4;
	localparam int VARINT_MAX   = 10;
	localparam int GROUP_W      = 7;
	localparam logic [7:0] GROUP_MASK = 8'h7f;
	localparam logic [7:0] MORE_BIT   = 8'h80;

	typedef enum logic [2:0] {
		OP_WR_FIX = 3'd0,
		OP_WR_VAR = 3'd1,
		OP_RD_FIX = 3'd2,
		OP_RD_VAR = 3'd3,
		OP_SET_WP = 3'd4,
		OP_SET_RP = 3'd5,
		OP_RESET  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WRITE,
		BK_RD_ADDR,
		BK_RD_DATA,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		op_t                op;
		logic [1:0]         size_code;
		logic [VAL_W-1:0]   value;
		logic [POS_W-1:0]   position;
		logic [VLEN_W-1:0]  vlen;
	} cmd_t;

endpackage

// ===== rtl/core/byte_buffer_serializer.sv =====
`timescale 1ns / 1ps
// Byte buffer with read and write positions over a CAPACITY-byte single-port
// store. Requests enter a two-item queue and run one at a time in the
// sequencer; the store takes one byte per cycle on writes and, since its read
// data is registered, steps through an address state and a data state for
// each byte on reads. One result item per request, held in an output register
// so the next request can start while it waits. Fixed-width values follow
// byte_order (reset 1, big endian), which the user must write through the cfg
// port only while the block is idle; the block itself does not enforce this.
module byte_buffer_serializer
	import bbs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // size_code, value, position, zero pad
	input  logic [2:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // read_value, varint_len, remain, zero pad
	output logic [1:0]  m_tuser    // status
);

	logic order_q;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b1;
		end else if (cfg_valid) begin
			order_q <= cfg_data;
		end
	end

	bbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	bbs_back #(.CAPACITY(CAPACITY)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_order (order_q),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== rtl/core/bbs_front.sv =====
`timescale 1ns / 1ps
module bbs_front
	import bbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // size_code, value, position, zero pad
	input  logic [2:0]  s_tuser,   // req_type
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	localparam int DEPTH = 2;

	cmd_t       fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       in_cmd;
	logic [VLEN_W-1:0] len;
	logic       push;
	logic       pop;

	// varint length: one byte per 7-bit group up to the highest nonzero one
	always_comb begin
		len = VLEN_W'(1);
		for (int k = 1; k < VARINT_MAX; k++) begin
			if ((s_tdata[65:2] >> (k * GROUP_W)) != '0) begin
				len = VLEN_W'(k + 1);
			end
		end
	end

	always_comb begin
		in_cmd.op        = op_t'(s_tuser);
		in_cmd.size_code = s_tdata[1:0];
		in_cmd.value     = s_tdata[65:2];
		in_cmd.position  = s_tdata[78:66];
		in_cmd.vlen      = len;
	end

	assign s_tready  = (count_q != 2'(DEPTH));
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/bbs_back.sv =====
`timescale 1ns / 1ps
module bbs_back
	import bbs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_order,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // read_value, varint_len, remain, zero pad
	output logic [1:0]  m_tuser    // status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = ($clog2(CAPACITY + 1) > POS_W) ? $clog2(CAPACITY + 1) : POS_W;

	logic [7:0] mem [CAPACITY];
	logic [7:0] rdata_q;

	bk_state_t state_q, state_d;
	cmd_t      cmd_q;
	logic      order_q;
	logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
	logic [3:0]    idx_q, idx_d;
	logic [VAL_W-1:0] acc_q, acc_d;
	status_t   st_q, st_d;
	logic [VAL_W-1:0] rval_q, rval_d;
	logic [VLEN_W-1:0] vlen_q, vlen_d;
	logic      mv_q;
	logic [87:0] md_q;
	logic [1:0]  mu_q;
	logic      out_load;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wbyte;
	logic          rd_en;

	logic [3:0]    nbytes, cur_n, wlen;
	logic [PW:0]   wp_ext, cap_ext;
	logic [PW-1:0] pos_ext, diff;
	logic          has_data;
	logic [5:0]    sh8;
	logic [5:0]    sh7;
	logic [VAL_W-1:0] grp, fix_sh;
	logic [VAL_W-1:0] acc_fix, acc_var;

	assign nbytes  = 4'd1 << cmd.size_code;
	assign cur_n   = 4'd1 << cmd_q.size_code;
	assign wp_ext  = {1'b0, wp_q};
	assign cap_ext = (PW + 1)'(CAPACITY);
	assign pos_ext = PW'(cmd.position);
	assign diff    = wp_q - rp_q;
	assign has_data = (wp_q > rp_q);

	// byte shifts: fixed width in either order, varint by 7-bit groups
	assign sh8    = order_q ? {3'(cur_n - 4'd1 - idx_q), 3'b000} : {idx_q[2:0], 3'b000};
	assign sh7    = 6'({2'b00, idx_q} * 6'd7);
	assign fix_sh = cmd_q.value >> sh8;
	assign grp    = cmd_q.value >> sh7;
	assign wlen   = (cmd_q.op == OP_WR_VAR) ? cmd_q.vlen : cur_n;
	assign acc_fix = acc_q | (VAL_W'(rdata_q) << sh8);
	assign acc_var = acc_q | (VAL_W'(rdata_q & GROUP_MASK) << sh7);

	assign cmd_ready = (state_q == BK_IDLE);
	assign out_load  = (state_q == BK_DONE) && (!mv_q || m_tready);

	always_comb begin
		state_d = state_q;
		wp_d    = wp_q;
		rp_d    = rp_q;
		idx_d   = idx_q;
		acc_d   = acc_q;
		st_d    = st_q;
		rval_d  = rval_q;
		vlen_d  = vlen_q;
		we      = 1'b0;
		waddr   = AW'(wp_q + PW'(idx_q));
		wbyte   = fix_sh[7:0];
		rd_en   = 1'b0;
		raddr   = rp_q[AW-1:0];
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					st_d   = ST_OK;
					rval_d = '0;
					vlen_d = '0;
					idx_d  = '0;
					acc_d  = '0;
					state_d = BK_DONE;
					case (cmd.op)
						OP_WR_FIX: begin
							if (wp_ext + (PW + 1)'(nbytes) > cap_ext) st_d = ST_FULL;
							else state_d = BK_WRITE;
						end
						OP_WR_VAR: begin
							if (wp_ext + (PW + 1)'(cmd.vlen) > cap_ext) st_d = ST_FULL;
							else state_d = BK_WRITE;
						end
						OP_RD_FIX: begin
							if (!has_data || diff < PW'(nbytes)) st_d = ST_SHORT;
							else state_d = BK_RD_ADDR;
						end
						OP_RD_VAR: state_d = BK_RD_ADDR;
						OP_SET_WP: begin
							if ({1'b0, pos_ext} > cap_ext) begin
								wp_d = PW'(CAPACITY);
								st_d = ST_FULL;
							end else begin
								wp_d = pos_ext;
							end
						end
						OP_SET_RP: rp_d = pos_ext;
						OP_RESET: begin
							wp_d = '0;
							rp_d = '0;
						end
						default: ;
					endcase
				end
			end
			BK_WRITE: begin
				we = 1'b1;
				if (cmd_q.op == OP_WR_VAR) begin
					wbyte = (idx_q == wlen - 4'd1) ? grp[7:0] : (grp[7:0] & GROUP_MASK) | MORE_BIT;
				end
				if (idx_q == wlen - 4'd1) begin
					wp_d = wp_q + PW'(wlen);
					if (cmd_q.op == OP_WR_VAR) vlen_d = wlen;
					state_d = BK_DONE;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			BK_RD_ADDR: begin
				if (!has_data) begin
					st_d    = ST_SHORT;
					state_d = BK_DONE;
				end else begin
					rd_en   = 1'b1;
					rp_d    = rp_q + PW'(1);
					state_d = BK_RD_DATA;
				end
			end
			BK_RD_DATA: begin
				state_d = BK_RD_ADDR;
				idx_d   = idx_q + 4'd1;
				if (cmd_q.op == OP_RD_FIX) begin
					acc_d = acc_fix;
					if (idx_q == cur_n - 4'd1) begin
						rval_d  = acc_fix;
						state_d = BK_DONE;
					end
				end else begin
					acc_d = acc_var;
					if ((rdata_q & MORE_BIT) == 8'h00) begin
						rval_d  = acc_var;
						state_d = BK_DONE;
					end else if (idx_q == 4'(VARINT_MAX - 1)) begin
						st_d    = ST_OVERFLOW;
						state_d = BK_DONE;
					end
				end
			end
			BK_DONE: begin
				if (out_load) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wbyte;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && cmd_valid) begin
			cmd_q   <= cmd;
			order_q <= byte_order;
		end
		acc_q  <= acc_d;
		idx_q  <= idx_d;
		st_q   <= st_d;
		rval_q <= rval_d;
		vlen_q <= vlen_d;
		if (out_load) begin
			md_q <= {7'd0, diff[POS_W-1:0] & {POS_W{has_data}}, vlen_q, rval_q};
			mu_q <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			if (out_load) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;
	assign m_tuser  = mu_q;

endmodule

// ===== rtl/core/bbs_checker.sv =====
`timescale 1ns / 1ps
module bbs_checker
	import bbs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_vlen_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67:64] != 4'd0 |-> m_tuser == ST_OK)
		else $error("varint length on failed item");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == 64'd0)
		else $error("read value on failed item");

	a_vlen_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[67:64] <= 4'(VARINT_MAX))
		else $error("varint length too large");

endmodule

bind byte_buffer_serializer bbs_checker u_bbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
